/* rtl/core/signal_flag_logic_store_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the signal flag store
// Each macro expands to one labeled concurrent assertion on clk and rst.
// ----------------------------------------------------------------------------
`ifndef SIGNAL_FLAG_LOGIC_STORE_MACROS_SVH
`define SIGNAL_FLAG_LOGIC_STORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SFLS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("signal flag store check failed");

// Next-cycle implication, disabled during reset
`define SFLS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("signal flag store check failed");

`endif

/* rtl/core/sfls_pkg.sv */
// ----------------------------------------------------------------------------
// sfls_pkg
// Payload types, command codes and controller/datapath links of the store.
// ----------------------------------------------------------------------------
package sfls_pkg;

  localparam int CMD_W     = 3;
  localparam int IDX_W     = 8;
  localparam int OP_W      = 2;
  localparam int COUNT_W   = 9;
  localparam int WORD_BITS = 64;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_READ        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SEND        = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_DEFAULT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_EVALUATE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FRAME_RESET = 3'd4;

  // Evaluate operator codes
  localparam logic [OP_W-1:0] OP_AND   = 2'd0;
  localparam logic [OP_W-1:0] OP_OR    = 2'd1;
  localparam logic [OP_W-1:0] OP_NOT   = 2'd2;
  localparam logic [OP_W-1:0] OP_TIMER = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
    logic [IDX_W-1:0] index_out;
    logic [OP_W-1:0]  op;
    logic             value;
  } item_t;

  typedef struct packed {
    logic current_bit;
    logic previous_bit;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic exec;
    logic load;
  } dp_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic result_busy;
  } dp_stat_t;

endpackage

/* rtl/core/signal_flag_logic_store.sv */
// ----------------------------------------------------------------------------
// signal_flag_logic_store
// Store of one-bit signals in current, previous and default planes.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   (item_valid/item_ready, item)     one command per transfer:
//                  read, send, set default, evaluate or frame reset.
//   result channel (result_valid/result_ready, result) one result per item:
//                  current and previous bit of index_a after the command.
//   cfg channel    (cfg_valid/cfg_ready, cfg_data)   signal_count; always
//                  ready, write it only while the block is idle.
// Sequence: an item passes through capture, plane update and result load in
//   turn; the sequencer holds one item at a time and takes no new item until
//   its result is loaded. The frame copy of the words that hold live signals
//   runs in the update step; the result register is loaded in the load step.
// Reset: rst clears all three planes, signal_count and the result valid.
// Stall: a waiting result holds in the output register; the sequencer stays
//   in the report step and takes no new item until the register frees up.
// ----------------------------------------------------------------------------
`include "signal_flag_logic_store_macros.svh"

module signal_flag_logic_store
  import sfls_pkg::*;
#(
  parameter int MAX_SIGNALS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  sfls_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  sfls_dp #(
    .MAX_SIGNALS (MAX_SIGNALS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  // One item in flight: no transfer right after a transfer
  `SFLS_ASSERT_NXT(a_one_in_flight, item_valid && item_ready, !item_ready)

  // Never overwrite a result that is still waiting
  `SFLS_ASSERT_IMP(a_no_overwrite, ctrl.load, !result_valid || result_ready)

  // A new result only appears after a load command
  `SFLS_ASSERT_IMP(a_valid_from_load, $rose(result_valid), $past(ctrl.load))

endmodule

/* rtl/core/sfls_ctrl.sv */
// ----------------------------------------------------------------------------
// sfls_ctrl
// Sequencer: take one item, apply it to the planes, then report the result.
// ----------------------------------------------------------------------------
module sfls_ctrl
  import sfls_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  dp_stat_t stat,
  output dp_ctrl_t ctrl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REPORT
  } state_t;

  state_t state;

  // Accept only when no item is in flight
  assign item_ready = (state == S_IDLE);

  // Issue datapath commands from the current state
  always_comb begin
    ctrl.latch = (state == S_IDLE) && item_valid;
    ctrl.exec  = (state == S_EXEC);
    ctrl.load  = (state == S_REPORT) && !stat.result_busy;
  end

  // Advance the sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_REPORT;
        end
        S_REPORT: begin
          if (!stat.result_busy) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/sfls_dp.sv */
// ----------------------------------------------------------------------------
// sfls_dp
// Flag planes, item register, signal count and result register.
// ----------------------------------------------------------------------------
module sfls_dp
  import sfls_pkg::*;
#(
  parameter int MAX_SIGNALS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_ctrl_t           ctrl,
  output dp_stat_t           stat,
  input  item_t              item,
  input  logic               cfg_valid,
  input  logic [COUNT_W-1:0] cfg_data,
  output result_t            result,
  output logic               result_valid,
  input  logic               result_ready
);

  localparam int WORDS   = (MAX_SIGNALS + WORD_BITS - 1) / WORD_BITS;
  localparam int PLANE_W = WORDS * WORD_BITS;
  localparam int BIT_W   = $clog2(PLANE_W);

  logic [COUNT_W-1:0] signal_count;
  logic [COUNT_W-1:0] live;
  item_t              item_q;

  logic [PLANE_W-1:0] cur_plane, prv_plane, dft_plane;
  logic [PLANE_W-1:0] cur_plane_next, prv_plane_next, dft_plane_next;

  logic [BIT_W-1:0] addr_a, addr_b, addr_send;
  logic             a_ok, b_ok, out_ok;
  logic             cur_a, cur_b, fire;
  logic             send_en, send_ok;

  // Clamp the count to the plane size
  assign live = (32'(signal_count) > MAX_SIGNALS) ? COUNT_W'(MAX_SIGNALS) : signal_count;

  assign a_ok   = {1'b0, item_q.index_a} < live;
  assign b_ok   = {1'b0, item_q.index_b} < live;
  assign out_ok = {1'b0, item_q.index_out} < live;

  assign addr_a = BIT_W'(item_q.index_a);
  assign addr_b = BIT_W'(item_q.index_b);

  // Out-of-range operands read as zero
  assign cur_a = a_ok && cur_plane[addr_a];
  assign cur_b = b_ok && cur_plane[addr_b];

  // Evaluate the operator
  always_comb begin
    unique case (item_q.op)
      OP_AND:   fire = cur_a && cur_b;
      OP_OR:    fire = cur_a || cur_b;
      OP_NOT:   fire = !cur_a;
      OP_TIMER: fire = 1'b0;
      default:  fire = 1'b0;
    endcase
  end

  // Pick the signal to send, if any
  always_comb begin
    send_en   = 1'b0;
    send_ok   = 1'b0;
    addr_send = addr_a;
    if (item_q.cmd == CMD_SEND) begin
      send_en = 1'b1;
      send_ok = a_ok;
    end else if (item_q.cmd == CMD_EVALUATE) begin
      send_en   = fire;
      send_ok   = out_ok;
      addr_send = BIT_W'(item_q.index_out);
    end
  end

  // Build the updated planes
  always_comb begin
    cur_plane_next = cur_plane;
    prv_plane_next = prv_plane;
    dft_plane_next = dft_plane;
    if (send_en && send_ok) begin
      cur_plane_next[addr_send] = ~dft_plane[addr_send];
    end
    if (item_q.cmd == CMD_SET_DEFAULT && a_ok) begin
      dft_plane_next[addr_a] = item_q.value;
    end
    if (item_q.cmd == CMD_FRAME_RESET) begin
      for (int w = 0; w < WORDS; w++) begin
        // Copy only words that hold a live signal
        if (32'(live) > w * WORD_BITS) begin
          prv_plane_next[w*WORD_BITS +: WORD_BITS] = cur_plane[w*WORD_BITS +: WORD_BITS];
          cur_plane_next[w*WORD_BITS +: WORD_BITS] = dft_plane[w*WORD_BITS +: WORD_BITS];
        end
      end
    end
  end

  // Hold the signal count
  always_ff @(posedge clk) begin
    if (rst) begin
      signal_count <= '0;
    end else if (cfg_valid) begin
      signal_count <= cfg_data;
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (ctrl.latch) item_q <= item;
  end

  // Update the planes
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_plane <= '0;
      prv_plane <= '0;
      dft_plane <= '0;
    end else if (ctrl.exec) begin
      cur_plane <= cur_plane_next;
      prv_plane <= prv_plane_next;
      dft_plane <= dft_plane_next;
    end
  end

  // Hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      result.current_bit  <= a_ok && cur_plane[addr_a];
      result.previous_bit <= a_ok && prv_plane[addr_a];
    end
  end

  assign stat.result_busy = result_valid && !result_ready;

endmodule
